[rtl/ffha_pkg.sv]
// shared types, constants and helper functions for the first-fit heap allocator
package ffha_pkg;

  localparam int ARENA_BYTES  = 16384;
  localparam int HDR_BYTES    = 32;
  localparam int MAX_BLOCKS   = 512;
  localparam int SPLIT_SLACK  = 16;
  localparam int MIN_HEAP     = 64;

  localparam int SZ_W     = 15;
  localparam int SLOT_W   = $clog2(MAX_BLOCKS);
  localparam int BM_W     = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
  localparam int BM_WORDS = MAX_BLOCKS / BM_W;
  localparam int BM_AW    = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
  localparam int BIT_W    = $clog2(BM_W);

  typedef logic [SZ_W-1:0]   sz_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOT_W:0]   link_t;
  typedef logic [BM_W-1:0]   bm_word_t;
  typedef logic [BM_AW-1:0]  bm_addr_t;
  typedef logic [BIT_W-1:0]  bit_t;

  localparam link_t NO_LINK = {1'b1, {SLOT_W{1'b0}}};

  typedef struct packed {
    sz_t   off;
    sz_t   bytes;
    logic  free;
    link_t nxt;
  } ent_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_BASE = 1'b0,
    REG_HEAP = 1'b1
  } reg_e;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_SCAN  = 11'b000_0000_0100,
    S_WALK  = 11'b000_0000_1000,
    S_SPLIT = 11'b000_0001_0000,
    S_TAKE  = 11'b000_0010_0000,
    S_FN    = 11'b000_0100_0000,
    S_CLRN  = 11'b000_1000_0000,
    S_P0    = 11'b001_0000_0000,
    S_P1    = 11'b010_0000_0000,
    S_CLRC  = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    state_e  op;
    logic    go_alloc;
    logic    go_free;
    logic    fin;
    status_e fin_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bm_found;
    logic scan_last;
    logic fit;
    logic split_ok;
    logic last;
    logic hit;
    logic hit_free;
    logic n_merge;
    logic p_valid;
    logic p_merge;
    logic clr_last;
    logic null_free;
  } dp_stat_t;

  function automatic bit_t first_zero(input bm_word_t w);
    bit_t idx;
    idx = '0;
    for (int i = BM_W - 1; i >= 0; i--) begin
      if (!w[i]) idx = bit_t'(i);
    end
    return idx;
  endfunction

  function automatic bm_addr_t word_of(input slot_t s);
    return bm_addr_t'(s >> BIT_W);
  endfunction

  function automatic bit_t bit_of(input slot_t s);
    return s[BIT_W-1:0];
  endfunction

  function automatic sz_t clamp_heap(input sz_t hb);
    sz_t r;
    if (hb < sz_t'(MIN_HEAP)) r = sz_t'(MIN_HEAP);
    else if (32'(hb) > 32'(ARENA_BYTES)) r = sz_t'(ARENA_BYTES);
    else r = hb;
    return r;
  endfunction

endpackage

[rtl/ffha_ctrl.sv]
// controller state machine of the heap allocator
module ffha_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 cmd_i,
  input  logic                 rebuild_i,
  input  ffha_pkg::dp_stat_t   stat_i,
  output ffha_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o
);

  ffha_pkg::state_e state_q, state_d;
  logic             free_q, free_d;
  logic             accept;

  assign busy_o = (state_q != ffha_pkg::S_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d           = state_q;
    free_d            = free_q;
    cmd_o.op          = state_q;
    cmd_o.go_alloc    = 1'b0;
    cmd_o.go_free     = 1'b0;
    cmd_o.fin         = 1'b0;
    cmd_o.fin_status  = ffha_pkg::ST_OK;
    case (state_q)
      ffha_pkg::S_CLEAR: begin
        if (stat_i.clr_last) state_d = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_IDLE: begin
        if (rebuild_i) begin
          state_d = ffha_pkg::S_CLEAR;
        end else if (accept) begin
          if (cmd_i == ffha_pkg::CMD_ALLOC) begin
            free_d         = 1'b0;
            cmd_o.go_alloc = 1'b1;
            state_d        = ffha_pkg::S_SCAN;
          end else if (stat_i.null_free) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ffha_pkg::ST_NULL;
          end else begin
            free_d        = 1'b1;
            cmd_o.go_free = 1'b1;
            state_d       = ffha_pkg::S_WALK;
          end
        end
      end
      ffha_pkg::S_SCAN: begin
        if (stat_i.bm_found || stat_i.scan_last) state_d = ffha_pkg::S_WALK;
      end
      ffha_pkg::S_WALK: begin
        if (!free_q) begin
          if (stat_i.fit) begin
            state_d = stat_i.split_ok ? ffha_pkg::S_SPLIT : ffha_pkg::S_TAKE;
          end else if (stat_i.last) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ffha_pkg::ST_NOFIT;
            state_d          = ffha_pkg::S_IDLE;
          end
        end else begin
          if (stat_i.hit && !stat_i.hit_free) begin
            state_d = ffha_pkg::S_FN;
          end else if (stat_i.hit || stat_i.last) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ffha_pkg::ST_UNKNOWN;
            state_d          = ffha_pkg::S_IDLE;
          end
        end
      end
      ffha_pkg::S_SPLIT: state_d = ffha_pkg::S_TAKE;
      ffha_pkg::S_TAKE: begin
        cmd_o.fin = 1'b1;
        state_d   = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_FN: begin
        state_d = stat_i.n_merge ? ffha_pkg::S_CLRN : ffha_pkg::S_P0;
      end
      ffha_pkg::S_CLRN: state_d = ffha_pkg::S_P0;
      ffha_pkg::S_P0: begin
        if (stat_i.p_valid) begin
          state_d = ffha_pkg::S_P1;
        end else begin
          cmd_o.fin = 1'b1;
          state_d   = ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_P1: begin
        if (stat_i.p_merge) begin
          state_d = ffha_pkg::S_CLRC;
        end else begin
          cmd_o.fin = 1'b1;
          state_d   = ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_CLRC: begin
        cmd_o.fin = 1'b1;
        state_d   = ffha_pkg::S_IDLE;
      end
      default: state_d = ffha_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_CLEAR;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
    end
  end

  // a null free answers at once without leaving idle
  a_null_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == ffha_pkg::CMD_FREE && stat_i.null_free) |->
    (cmd_o.fin && cmd_o.fin_status == ffha_pkg::ST_NULL))
    else $error("null free not answered at once");

  a_split_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_SPLIT) |=> (state_q == ffha_pkg::S_TAKE))
    else $error("split not followed by take");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> (state_q == ffha_pkg::S_IDLE))
    else $error("transaction finished but controller not idle");

endmodule

[rtl/ffha_dp.sv]
// datapath of the heap allocator: block table, link memory, slot bitmap, result
module ffha_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffha_pkg::ctrl_cmd_t cmd_i,
  input  logic [14:0]         req_bytes_i,
  input  logic [31:0]         free_addr_i,
  input  logic [31:0]         base_addr_i,
  input  logic [14:0]         heap_bytes_i,
  output ffha_pkg::dp_stat_t  stat_o,
  output logic                done_o,
  output logic [31:0]         addr_o,
  output logic [1:0]          status_o
);

  ffha_pkg::ent_t     main_mem [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::link_t    prev_mem [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::bm_word_t bm_mem   [ffha_pkg::BM_WORDS];

  ffha_pkg::ent_t     main_rd_q, main_wd;
  ffha_pkg::slot_t    main_ra, main_wa;
  logic               main_we;
  ffha_pkg::link_t    prev_rd_q, prev_wd;
  ffha_pkg::slot_t    prev_ra, prev_wa;
  logic               prev_we;
  ffha_pkg::bm_word_t bm_rd_q, bm_wd;
  ffha_pkg::bm_addr_t bm_ra, bm_wa;
  logic               bm_we;

  ffha_pkg::slot_t    cur_q, cur_d, nclr_q, nclr_d;
  ffha_pkg::ent_t     ent_q, ent_d;
  ffha_pkg::link_t    ns_q, ns_d, p_q, p_d;
  ffha_pkg::bm_word_t bmw_q, bmw_d;
  ffha_pkg::bm_addr_t w_q, w_d, c_q, c_d;
  ffha_pkg::sz_t      req_q, req_d;
  logic [31:0]        target_q, target_d, addr_q, addr_d;
  logic               split_q, split_d, free_q, free_d;
  logic               done_q;
  ffha_pkg::status_e  status_q;
  logic [31:0]        res_addr_q;

  ffha_pkg::ent_t     rd;
  ffha_pkg::sz_t      heap_c;
  logic [15:0]        need;
  logic               stop;

  always_ff @(posedge clk_i) begin
    if (main_we) main_mem[main_wa] <= main_wd;
    main_rd_q <= main_mem[main_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_q <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_rd_q <= bm_mem[bm_ra];
  end

  assign rd     = main_rd_q;
  assign heap_c = ffha_pkg::clamp_heap(heap_bytes_i);
  assign need   = {1'b0, req_q} + 16'(ffha_pkg::HDR_BYTES + ffha_pkg::SPLIT_SLACK);

  always_comb begin
    stat_o.bm_found  = (bm_rd_q != '1);
    stat_o.scan_last = (w_q == ffha_pkg::bm_addr_t'(ffha_pkg::BM_WORDS - 1));
    stat_o.fit       = rd.free && (rd.bytes >= req_q);
    stat_o.split_ok  = !ns_q[ffha_pkg::SLOT_W] && ({1'b0, rd.bytes} >= need);
    stat_o.last      = rd.nxt[ffha_pkg::SLOT_W];
    stat_o.hit       = ({17'b0, rd.off} == target_q);
    stat_o.hit_free  = rd.free;
    stat_o.n_merge   = !ent_q.nxt[ffha_pkg::SLOT_W] && rd.free;
    stat_o.p_valid   = !p_q[ffha_pkg::SLOT_W];
    stat_o.p_merge   = rd.free;
    stat_o.clr_last  = (c_q == ffha_pkg::bm_addr_t'(ffha_pkg::BM_WORDS - 1));
    stat_o.null_free = (free_addr_i == 32'd0);
  end

  always_comb begin
    main_we  = 1'b0;
    main_wa  = cur_q;
    main_wd  = ent_q;
    main_ra  = cur_q;
    prev_we  = 1'b0;
    prev_wa  = cur_q;
    prev_wd  = ffha_pkg::NO_LINK;
    prev_ra  = cur_q;
    bm_we    = 1'b0;
    bm_wa    = w_q;
    bm_wd    = bm_rd_q;
    bm_ra    = w_q;
    cur_d    = cur_q;
    nclr_d   = nclr_q;
    ent_d    = ent_q;
    ns_d     = ns_q;
    p_d      = p_q;
    bmw_d    = bmw_q;
    w_d      = w_q;
    c_d      = '0;
    req_d    = req_q;
    target_d = target_q;
    addr_d   = addr_q;
    split_d  = split_q;
    free_d   = free_q;
    stop     = 1'b0;
    case (cmd_i.op)
      ffha_pkg::S_CLEAR: begin
        // one bitmap word per cycle, slot 0 rebuilt as the whole arena
        main_we       = 1'b1;
        main_wa       = '0;
        main_wd.off   = '0;
        main_wd.bytes = heap_c - ffha_pkg::sz_t'(ffha_pkg::HDR_BYTES);
        main_wd.free  = 1'b1;
        main_wd.nxt   = ffha_pkg::NO_LINK;
        prev_we       = 1'b1;
        prev_wa       = '0;
        bm_we         = 1'b1;
        bm_wa         = c_q;
        bm_wd         = (c_q == '0) ? ffha_pkg::bm_word_t'(1) : '0;
        c_d           = c_q + ffha_pkg::bm_addr_t'(1);
      end
      ffha_pkg::S_IDLE: begin
        if (cmd_i.go_alloc) begin
          w_d     = '0;
          bm_ra   = '0;
          split_d = 1'b0;
          free_d  = 1'b0;
          req_d   = req_bytes_i;
        end
        if (cmd_i.go_free) begin
          target_d = free_addr_i - base_addr_i - 32'(ffha_pkg::HDR_BYTES);
          main_ra  = '0;
          cur_d    = '0;
          free_d   = 1'b1;
          addr_d   = '0;
        end
      end
      ffha_pkg::S_SCAN: begin
        bmw_d = bm_rd_q;
        ns_d  = stat_o.bm_found ?
                ffha_pkg::link_t'({w_q, ffha_pkg::first_zero(bm_rd_q)}) : ffha_pkg::NO_LINK;
        if (stat_o.bm_found || stat_o.scan_last) begin
          main_ra = '0;
          cur_d   = '0;
        end else begin
          w_d   = w_q + ffha_pkg::bm_addr_t'(1);
          bm_ra = w_q + ffha_pkg::bm_addr_t'(1);
        end
      end
      ffha_pkg::S_WALK: begin
        stop = free_q ? stat_o.hit : stat_o.fit;
        if (!stop) begin
          cur_d   = rd.nxt[ffha_pkg::SLOT_W-1:0];
          main_ra = rd.nxt[ffha_pkg::SLOT_W-1:0];
        end else begin
          ent_d = rd;
          if (free_q) begin
            ent_d.free = 1'b1;
            main_ra    = rd.nxt[ffha_pkg::SLOT_W-1:0];
            prev_ra    = cur_q;
          end else begin
            addr_d = base_addr_i + 32'(rd.off) + 32'(ffha_pkg::HDR_BYTES);
          end
        end
      end
      ffha_pkg::S_SPLIT: begin
        main_we       = 1'b1;
        main_wa       = ns_q[ffha_pkg::SLOT_W-1:0];
        main_wd.off   = ent_q.off + ffha_pkg::sz_t'(ffha_pkg::HDR_BYTES) + req_q;
        main_wd.bytes = ent_q.bytes - req_q - ffha_pkg::sz_t'(ffha_pkg::HDR_BYTES);
        main_wd.free  = 1'b1;
        main_wd.nxt   = ent_q.nxt;
        prev_we       = 1'b1;
        prev_wa       = ns_q[ffha_pkg::SLOT_W-1:0];
        prev_wd       = {1'b0, cur_q};
        bm_we         = 1'b1;
        bm_wa         = ffha_pkg::word_of(ns_q[ffha_pkg::SLOT_W-1:0]);
        bm_wd         = bmw_q |
                        (ffha_pkg::bm_word_t'(1) << ffha_pkg::bit_of(ns_q[ffha_pkg::SLOT_W-1:0]));
        split_d       = 1'b1;
      end
      ffha_pkg::S_TAKE: begin
        main_we      = 1'b1;
        main_wd.free = 1'b0;
        if (split_q) begin
          main_wd.bytes = req_q;
          main_wd.nxt   = ns_q;
          prev_we       = !ent_q.nxt[ffha_pkg::SLOT_W];
          prev_wa       = ent_q.nxt[ffha_pkg::SLOT_W-1:0];
          prev_wd       = ns_q;
        end
      end
      ffha_pkg::S_FN: begin
        p_d = prev_rd_q;
        if (stat_o.n_merge) begin
          ent_d.bytes = ent_q.bytes + rd.bytes + ffha_pkg::sz_t'(ffha_pkg::HDR_BYTES);
          ent_d.nxt   = rd.nxt;
          prev_we     = !rd.nxt[ffha_pkg::SLOT_W];
          prev_wa     = rd.nxt[ffha_pkg::SLOT_W-1:0];
          prev_wd     = {1'b0, cur_q};
          nclr_d      = ent_q.nxt[ffha_pkg::SLOT_W-1:0];
          bm_ra       = ffha_pkg::word_of(ent_q.nxt[ffha_pkg::SLOT_W-1:0]);
        end
      end
      ffha_pkg::S_CLRN: begin
        bm_we = 1'b1;
        bm_wa = ffha_pkg::word_of(nclr_q);
        bm_wd = bm_rd_q & ~(ffha_pkg::bm_word_t'(1) << ffha_pkg::bit_of(nclr_q));
      end
      ffha_pkg::S_P0: begin
        main_we = 1'b1;
        main_ra = p_q[ffha_pkg::SLOT_W-1:0];
      end
      ffha_pkg::S_P1: begin
        if (stat_o.p_merge) begin
          main_we       = 1'b1;
          main_wa       = p_q[ffha_pkg::SLOT_W-1:0];
          main_wd       = rd;
          main_wd.bytes = rd.bytes + ent_q.bytes + ffha_pkg::sz_t'(ffha_pkg::HDR_BYTES);
          main_wd.nxt   = ent_q.nxt;
          prev_we       = !ent_q.nxt[ffha_pkg::SLOT_W];
          prev_wa       = ent_q.nxt[ffha_pkg::SLOT_W-1:0];
          prev_wd       = p_q;
          bm_ra         = ffha_pkg::word_of(cur_q);
        end
      end
      ffha_pkg::S_CLRC: begin
        bm_we = 1'b1;
        bm_wa = ffha_pkg::word_of(cur_q);
        bm_wd = bm_rd_q & ~(ffha_pkg::bm_word_t'(1) << ffha_pkg::bit_of(cur_q));
      end
      default: c_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    nclr_q   <= nclr_d;
    ent_q    <= ent_d;
    ns_q     <= ns_d;
    p_q      <= p_d;
    bmw_q    <= bmw_d;
    w_q      <= w_d;
    req_q    <= req_d;
    target_q <= target_d;
    addr_q   <= addr_d;
    split_q  <= split_d;
    free_q   <= free_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q    <= '0;
      done_q <= 1'b0;
    end else begin
      c_q    <= c_d;
      done_q <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= cmd_i.fin_status;
    res_addr_q <= (cmd_i.fin_status == ffha_pkg::ST_OK && !free_q) ? addr_q : 32'd0;
  end

  assign done_o   = done_q;
  assign addr_o   = res_addr_q;
  assign status_o = status_q;

endmodule

[rtl/first_fit_heap_allocator.sv]
// top level of the first-fit heap allocator with coalescing and its register port
//
// one arena is kept as an address-ordered, doubly linked list of blocks, each with a
// header; start/busy take one transaction at a time and the result comes back as a
// one-cycle done_o strobe that the receiver cannot hold off. an allocate first scans
// the slot bitmap for the lowest unused slot (one 32-slot word per cycle over up to
// BM_WORDS words, 16 by default), then walks the block list one block per cycle
// from the first block, then updates in the split and take states or in take alone.
// a free walks the list for the block's header (one block per cycle), then merges
// with its neighbors in FN and P0 and, as needed, CLRN, P1 and CLRC; a free of address
// zero is answered from idle without a walk. the walk over the block table memory
// sets the rate. after reset and after each heap_bytes write taken while idle, a
// clearing pass over the BM_WORDS bitmap words rebuilds the arena with busy high.
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [14:0] req_bytes_i,
  input  logic [31:0] free_addr_i,
  // result channel
  output logic        done_o,
  output logic [31:0] addr_o,
  output logic [1:0]  status_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ffha_pkg::ctrl_cmd_t cmd;
  ffha_pkg::dp_stat_t  stat;
  logic [31:0]         base_q;
  logic [14:0]         heap_q;
  logic                wr;
  logic                rebuild;
  ffha_pkg::reg_e      reg_sel;

  // registers sit at byte addresses 0 and 4
  assign pready  = 1'b1;
  assign reg_sel = ffha_pkg::reg_e'(paddr[2]);
  assign wr      = psel && penable && pwrite && pready;
  // a heap size write taken while idle rebuilds the arena; a base write only shifts returned and freed addresses
  assign rebuild = wr && (reg_sel == ffha_pkg::REG_HEAP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd65536;
      heap_q <= 15'd16384;
    end else if (wr) begin
      case (reg_sel)
        ffha_pkg::REG_BASE: base_q <= pwdata;
        ffha_pkg::REG_HEAP: heap_q <= pwdata[14:0];
        default: base_q <= base_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ffha_pkg::REG_BASE: prdata = base_q;
      ffha_pkg::REG_HEAP: prdata = {17'b0, heap_q};
      default:            prdata = 32'd0;
    endcase
  end

  // sequencing of scan, walk, split and merge steps
  ffha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cmd_i     (cmd_i),
    .rebuild_i (rebuild),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  // block table, links, slot bitmap and result registers
  ffha_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_bytes_i  (req_bytes_i),
    .free_addr_i  (free_addr_i),
    .base_addr_i  (base_q),
    .heap_bytes_i (heap_q),
    .stat_o       (stat),
    .done_o       (done_o),
    .addr_o       (addr_o),
    .status_o     (status_o)
  );

endmodule

[test/testbench.sv]
// self-checking testbench for the first-fit heap allocator: directed table, then random traffic
`timescale 1ns / 100ps

module testbench;
  import ffha_pkg::*;

  typedef struct {
    logic [31:0] addr;
    status_e     status;
  } answer_t;

  typedef struct {
    cmd_e        cmd;
    logic [14:0] req;
    logic [31:0] faddr;
    bit          typed;    // expected answer written out in the row
    logic [31:0] exp_addr;
    status_e     exp_status;
  } row_t;

  localparam int NONE  = -1;
  localparam int NROWS = 17;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cmd;
  logic [14:0] req_bytes;
  logic [31:0] free_addr;
  logic        done_o;
  logic [31:0] addr_o;
  logic [1:0]  status_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the block table
  logic [31:0] base_q;
  int          blk_off  [MAX_BLOCKS];
  int          blk_len  [MAX_BLOCKS];
  bit          blk_open [MAX_BLOCKS];
  int          blk_next [MAX_BLOCKS];
  int          blk_prev [MAX_BLOCKS];
  bit          blk_live [MAX_BLOCKS];

  answer_t     pending_q[$];   // answers still owed by the block
  logic [31:0] granted_q[$];   // payload addresses currently handed out
  int          errors;
  bit          typed_next;
  answer_t     typed_ans;
  row_t        rows [NROWS];

  first_fit_heap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .req_bytes_i (req_bytes),
    .free_addr_i (free_addr),
    .done_o      (done_o),
    .addr_o      (addr_o),
    .status_o    (status_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // rebuild the arena as one free block
  function automatic void rebuild_arena(input logic [31:0] value);
    int hb;
    hb = int'(value & 32'h7fff);
    if (hb < MIN_HEAP) hb = MIN_HEAP;
    if (hb > ARENA_BYTES) hb = ARENA_BYTES;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      blk_off[i] = 0; blk_len[i] = 0; blk_open[i] = 0;
      blk_next[i] = 0; blk_prev[i] = 0; blk_live[i] = 0;
    end
    blk_len[0]  = hb - HDR_BYTES;
    blk_open[0] = 1;
    blk_next[0] = NONE;
    blk_prev[0] = NONE;
    blk_live[0] = 1;
    granted_q.delete();
  endfunction

  function automatic answer_t alloc_predict(input int req);
    answer_t r;
    int cur, spare, after;
    cur = 0;
    for (int steps = 0; steps < MAX_BLOCKS && cur != NONE; steps++) begin
      if (blk_live[cur] && blk_open[cur] && blk_len[cur] >= req) begin
        spare = NONE;
        for (int i = 1; i < MAX_BLOCKS; i++)
          if (!blk_live[i] && spare == NONE) spare = i;
        if (blk_len[cur] >= req + HDR_BYTES + SPLIT_SLACK && spare != NONE) begin
          after = blk_next[cur];
          blk_off[spare]  = blk_off[cur] + HDR_BYTES + req;
          blk_len[spare]  = blk_len[cur] - req - HDR_BYTES;
          blk_open[spare] = 1;
          blk_next[spare] = after;
          blk_prev[spare] = cur;
          blk_live[spare] = 1;
          if (after != NONE) blk_prev[after] = spare;
          blk_len[cur]  = req;
          blk_next[cur] = spare;
        end
        blk_open[cur] = 0;
        r.addr   = base_q + 32'(blk_off[cur]) + 32'(HDR_BYTES);
        r.status = ST_OK;
        granted_q.push_back(r.addr);
        return r;
      end
      cur = blk_next[cur];
    end
    r.addr   = '0;
    r.status = ST_NOFIT;
    return r;
  endfunction

  // absorb the successor of block b
  function automatic void absorb_next(input int b);
    int n, after;
    n = blk_next[b];
    if (n == NONE) return;
    after = blk_next[n];
    blk_len[b] += blk_len[n] + HDR_BYTES;
    blk_next[b] = after;
    if (after != NONE) blk_prev[after] = b;
    blk_live[n] = 0;
    blk_open[n] = 0;
  endfunction

  function automatic answer_t release_predict(input logic [31:0] fa);
    answer_t r;
    logic [31:0] target;
    int cur, hit;
    r.addr = '0;
    if (fa == 0) begin
      r.status = ST_NULL;
      return r;
    end
    target = fa - base_q - 32'(HDR_BYTES);
    cur = 0;
    hit = NONE;
    for (int steps = 0; steps < MAX_BLOCKS && cur != NONE && hit == NONE; steps++) begin
      if (blk_live[cur] && 32'(blk_off[cur]) == target) hit = cur;
      else cur = blk_next[cur];
    end
    if (hit == NONE || blk_open[hit]) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    blk_open[hit] = 1;
    if (blk_next[hit] != NONE && blk_open[blk_next[hit]]) absorb_next(hit);
    if (blk_prev[hit] != NONE && blk_open[blk_prev[hit]]) absorb_next(blk_prev[hit]);
    foreach (granted_q[i])
      if (granted_q[i] == fa) begin
        granted_q.delete(i);
        break;
      end
    r.status = ST_OK;
    return r;
  endfunction

  // acceptance and checking share one process so a same-cycle answer cannot race
  always @(posedge clk_i) begin
    answer_t a, e;
    if (rst_ni && start && !busy) begin
      if (cmd == CMD_ALLOC) a = alloc_predict(int'(req_bytes));
      else a = release_predict(free_addr);
      pending_q.push_back(typed_next ? typed_ans : a);
    end
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result addr %h status %0d", $time, addr_o, status_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (addr_o !== e.addr) begin
          $display("%0t: addr expected %h actual %h", $time, e.addr, addr_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
      end
    end
  end

  task automatic issue(input cmd_e c, input logic [14:0] rq, input logic [31:0] fa);
    start     <= 1'b1;
    cmd       <= c;
    req_bytes <= rq;
    free_addr <= fa;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // setup then access phase; register written at the access edge
  task automatic reg_write(input reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (r == REG_BASE) base_q = v;
    else rebuild_arena(v);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_traffic(input int count, input int idle_pct);
    int pick;
    logic [31:0] fa;
    logic [14:0] rq;
    for (int k = 0; k < count; k++) begin
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        case ($urandom_range(9))
          0:       rq = 15'($urandom);
          1:       rq = 15'($urandom_range(ARENA_BYTES));
          2:       rq = 15'($urandom_range(16));
          default: rq = 15'($urandom_range(400));
        endcase
        issue(CMD_ALLOC, rq, $urandom);
      end else begin
        pick = $urandom_range(99);
        if (pick < 75 && granted_q.size() != 0)
          fa = granted_q[$urandom_range(granted_q.size() - 1)];
        else if (pick < 85) fa = '0;
        else if (pick < 92) fa = base_q + 32'(HDR_BYTES) + 32'($urandom_range(ARENA_BYTES));
        else fa = $urandom;
        issue(CMD_FREE, 15'($urandom), fa);
      end
    end
  endtask

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [31:0] bases [6];
    logic [31:0] heaps [6];
    errors     = 0;
    typed_next <= 0;
    base_q     = 32'd65536;
    rebuild_arena(32'(ARENA_BYTES));
    rst_ni    = 1'b0;
    start     = 1'b0;
    cmd       = CMD_ALLOC;
    req_bytes = '0;
    free_addr = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    // after reset: base 0x10000, one free block of 16352 bytes
    rows = '{
      '{CMD_ALLOC, 15'd100,   32'h0,        1, 32'h0001_0020, ST_OK},
      '{CMD_ALLOC, 15'h7fff,  32'h0,        1, 32'h0,         ST_NOFIT},
      '{CMD_ALLOC, 15'd16384, 32'h0,        1, 32'h0,         ST_NOFIT},
      '{CMD_FREE,  15'h7fff,  32'h0,        1, 32'h0,         ST_NULL},
      '{CMD_FREE,  15'd0,     32'h1,        1, 32'h0,         ST_UNKNOWN},
      '{CMD_FREE,  15'd0,     32'hffff_ffff,1, 32'h0,         ST_UNKNOWN},
      '{CMD_FREE,  15'd0,     32'h0001_0020,1, 32'h0,         ST_OK},
      '{CMD_FREE,  15'd0,     32'h0001_0020,1, 32'h0,         ST_UNKNOWN},
      '{CMD_ALLOC, 15'd0,     32'h0,        1, 32'h0001_0020, ST_OK},
      '{CMD_ALLOC, 15'd16320, 32'h0,        1, 32'h0001_0040, ST_OK},
      '{CMD_ALLOC, 15'd0,     32'h0,        1, 32'h0,         ST_NOFIT},
      '{CMD_FREE,  15'd0,     32'h0001_0040,0, 32'h0,         ST_OK},
      '{CMD_FREE,  15'd0,     32'h0001_0020,0, 32'h0,         ST_OK},
      '{CMD_ALLOC, 15'd16352, 32'h0,        1, 32'h0001_0020, ST_OK},
      '{CMD_FREE,  15'd0,     32'h0001_0020,0, 32'h0,         ST_OK},
      '{CMD_ALLOC, 15'd16305, 32'h0,        0, 32'h0,         ST_OK},
      '{CMD_ALLOC, 15'd10,    32'h0,        0, 32'h0,         ST_OK}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // row expectations change at the accepting edge, after the checker has sampled them
    for (int i = 0; i < NROWS; i++) begin
      typed_next <= rows[i].typed;
      typed_ans  <= '{rows[i].exp_addr, rows[i].exp_status};
      issue(rows[i].cmd, rows[i].req, rows[i].faddr);
    end
    start <= 1'b0;
    @(posedge clk_i);
    typed_next <= 0;
    drain();

    // base only: arena kept, returned addresses shift and wrap
    reg_write(REG_BASE, 32'hffff_fff0);
    random_traffic(40, 7);
    drain();

    // register settings, extremes and out-of-range heap sizes among them
    bases = '{32'h0, 32'hffff_0000, 32'h0001_0000, 32'h1234_5678, 32'h8000_0000, 32'hffff_0000};
    heaps = '{32'd64, 32'd16384, 32'd0, 32'h7fff, 32'd1000, 32'd200};
    for (int p = 0; p < 6; p++) begin
      reg_write(REG_BASE, bases[p]);
      reg_write(REG_HEAP, heaps[p]);
      random_traffic(30, 7);
      random_traffic(30, 77);
      drain();   // sender holds off until every answer is in
      random_traffic(35, 0);
      drain();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
